>>> hw/rtl/swmr_pkg.sv
package swmr_pkg;

  localparam int HALF_WINDOW = 2400;
  localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
  localparam int SAMPLE_W    = 8;
  localparam int BINS        = 2 ** SAMPLE_W;
  localparam int CNT_W       = 13;
  localparam int RES_W       = SAMPLE_W + 1;
  localparam int PTR_W       = $clog2(WIN_LEN);
  localparam int SEEN_W      = $clog2(WIN_LEN + 1);
  localparam int CUM_W       = CNT_W + SAMPLE_W;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [SEEN_W-1:0]   seen_t;
  typedef logic [CUM_W-1:0]    cum_t;
  typedef logic signed [RES_W-1:0] resid_t;

  // count added on the very first sample: padding plus the sample itself
  localparam cnt_t FIRST_INC = cnt_t'(HALF_WINDOW + 1);
  localparam cnt_t ONE_INC   = cnt_t'(1);
  // offset that steps a ring pointer back by the half window
  localparam logic [PTR_W:0] BACK_OFF = (PTR_W + 1)'(WIN_LEN - HALF_WINDOW);
  localparam logic [PTR_W:0] WIN_LEN_X = (PTR_W + 1)'(WIN_LEN);
  localparam ptr_t  LAST_PTR   = ptr_t'(WIN_LEN - 1);
  localparam seen_t SEEN_FULL  = seen_t'(WIN_LEN);
  localparam seen_t SEEN_HALF  = seen_t'(HALF_WINDOW);
  localparam seen_t SEEN_TWICE = seen_t'(2 * HALF_WINDOW);
  localparam cum_t  CUM_HALF   = cum_t'(HALF_WINDOW);
  localparam sample_t LAST_BIN = sample_t'(BINS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_CTR,
    ST_OLD,
    ST_MED,
    ST_DEC,
    ST_FIN
  } seq_state_t;

  typedef struct packed {
    logic    en;
    logic    we;
    ptr_t    addr;
    sample_t wdata;
  } dl_req_t;

  typedef struct packed {
    logic    en;
    logic    we;
    sample_t addr;
    cnt_t    wdata;
  } hist_req_t;

  typedef struct packed {
    logic    valid;
    sample_t median;
    resid_t  residual;
  } res_t;

endpackage

>>> hw/rtl/swmr_ram.sv
module swmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> hw/rtl/swmr_hist.sv
module swmr_hist (
  input  logic               clk,
  input  logic               rst,
  input  swmr_pkg::hist_req_t req,
  output swmr_pkg::cnt_t     rdata
);
  import swmr_pkg::*;

  logic [BINS-1:0] vld;
  logic            vld_q;
  cnt_t            ram_rdata;

  // per-bin valid bits: a bin never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else if (req.en) begin
      if (req.we) begin
        vld[req.addr] <= 1'b1;
      end else begin
        vld_q <= vld[req.addr];
      end
    end
  end

  swmr_ram #(
    .WIDTH(CNT_W),
    .DEPTH(BINS)
  ) u_ram (
    .clk  (clk),
    .en   (req.en),
    .we   (req.we),
    .addr (req.addr),
    .wdata(req.wdata),
    .rdata(ram_rdata)
  );

  assign rdata = vld_q ? ram_rdata : '0;

endmodule

>>> hw/rtl/swmr_seq.sv
module swmr_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  swmr_pkg::sample_t   sample,
  output swmr_pkg::dl_req_t   dl_req,
  input  swmr_pkg::sample_t   dl_rdata,
  output swmr_pkg::hist_req_t hist_req,
  input  swmr_pkg::cnt_t      hist_rdata,
  output swmr_pkg::res_t      res,
  input  logic                res_ready
);
  import swmr_pkg::*;

  seq_state_t state, state_next;

  sample_t x;
  logic    first;
  ptr_t    wp;
  seen_t   seen;
  sample_t centre;
  sample_t old;
  sample_t median_q;
  cum_t    cum;
  sample_t iss;
  sample_t lag_bin;
  logic    lag_valid;

  logic            accept;
  logic            have_res;
  ptr_t            wp_inc;
  ptr_t            old_addr;
  logic [PTR_W:0]  back_sum;
  ptr_t            ctr_addr;
  cum_t            cum_next;
  logic            med_done;
  logic            fin_go;

  assign accept   = in_valid && in_ready;
  assign have_res = seen >= SEEN_HALF;
  assign wp_inc   = (wp == LAST_PTR) ? '0 : wp + ptr_t'(1);
  // while padding is still in the window the oldest value sits in slot 0
  assign old_addr = (seen < SEEN_TWICE) ? '0 : wp_inc;
  assign back_sum = {1'b0, wp} + BACK_OFF;
  assign ctr_addr = (back_sum >= WIN_LEN_X) ? ptr_t'(back_sum - WIN_LEN_X)
                                            : ptr_t'(back_sum);
  assign cum_next = cum + cum_t'(hist_rdata);
  assign med_done = lag_valid && ((cum_next > CUM_HALF) || (lag_bin == LAST_BIN));
  assign fin_go   = !have_res || res_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_INC;
      ST_INC:  state_next = have_res ? ST_CTR : ST_FIN;
      ST_CTR:  state_next = ST_OLD;
      ST_OLD:  state_next = ST_MED;
      ST_MED:  if (med_done) state_next = ST_DEC;
      ST_DEC:  state_next = ST_FIN;
      ST_FIN:  if (fin_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    dl_req         = '0;
    hist_req       = '0;
    res.valid      = 1'b0;
    res.median     = median_q;
    res.residual   = resid_t'({1'b0, centre} - {1'b0, median_q});
    unique case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        dl_req.en      = accept;
        dl_req.we      = 1'b1;
        dl_req.addr    = wp;
        dl_req.wdata   = sample;
        hist_req.en    = accept;
        hist_req.addr  = sample;
      end
      ST_INC: begin
        hist_req.en    = 1'b1;
        hist_req.we    = 1'b1;
        hist_req.addr  = x;
        hist_req.wdata = hist_rdata + (first ? FIRST_INC : ONE_INC);
        dl_req.en      = have_res;
        dl_req.addr    = ctr_addr;
      end
      ST_CTR: begin
        dl_req.en      = 1'b1;
        dl_req.addr    = old_addr;
      end
      ST_OLD: begin
      end
      ST_MED: begin
        hist_req.en    = 1'b1;
        hist_req.addr  = med_done ? old : iss;
      end
      ST_DEC: begin
        hist_req.en    = hist_rdata != '0;
        hist_req.we    = 1'b1;
        hist_req.addr  = old;
        hist_req.wdata = hist_rdata - cnt_t'(1);
      end
      ST_FIN: begin
        res.valid      = have_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp    <= '0;
      seen  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_FIN && fin_go) begin
        wp <= wp_inc;
        if (seen < SEEN_FULL) seen <= seen + seen_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x     <= sample;
      first <= seen == '0;
    end
    if (state == ST_CTR) centre <= dl_rdata;
    if (state == ST_OLD) begin
      old       <= dl_rdata;
      cum       <= '0;
      iss       <= '0;
      lag_valid <= 1'b0;
    end
    if (state == ST_MED) begin
      if (lag_valid) cum <= cum_next;
      lag_bin   <= iss;
      lag_valid <= 1'b1;
      iss       <= iss + sample_t'(1);
      if (med_done) median_q <= lag_bin;
    end
  end

endmodule

>>> hw/rtl/sliding_window_median_residual.sv
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------
// input    | in_valid / in_ready   | sample (8b unsigned)
// output   | out_valid / out_ready | median (8b unsigned), residual (9b signed)
//
// one sample is taken per pass of the sequencer; in_ready is high only when idle
// a pass runs IDLE, INC, FIN before half a window has been seen, then adds CTR, OLD,
// MED, DEC; MED scans the histogram one bin per cycle up to the median bin (at most 255)
// the histogram is a single-port ram whose per-bin valid bits reset clears at once
// a finished beat waits in the output register; a stalled output holds the sequencer
// in its final step only when a second result would overwrite the waiting beat
module sliding_window_median_residual (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  swmr_pkg::sample_t sample,
  output logic              out_valid,
  input  logic              out_ready,
  output swmr_pkg::sample_t median,
  output swmr_pkg::resid_t  residual
);
  import swmr_pkg::*;

  dl_req_t   dl_req;
  sample_t   dl_rdata;
  hist_req_t hist_req;
  cnt_t      hist_rdata;
  res_t      res;
  logic      res_ready;

  // ring of the last window of samples
  swmr_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WIN_LEN)
  ) u_delay (
    .clk  (clk),
    .en   (dl_req.en),
    .we   (dl_req.we),
    .addr (dl_req.addr),
    .wdata(dl_req.wdata),
    .rdata(dl_rdata)
  );

  // value counts of the window
  swmr_hist u_hist (
    .clk  (clk),
    .rst  (rst),
    .req  (hist_req),
    .rdata(hist_rdata)
  );

  // insert, median scan, removal of the oldest value
  swmr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .dl_req    (dl_req),
    .dl_rdata  (dl_rdata),
    .hist_req  (hist_req),
    .hist_rdata(hist_rdata),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      median   <= res.median;
      residual <= res.residual;
    end
  end

endmodule

>>> hw/rtl/swmr_chk.sv
module swmr_chk (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input swmr_pkg::sample_t median,
  input swmr_pkg::resid_t  residual
);
  import swmr_pkg::*;

  logic [RES_W:0] centre_chk;

  // centre sample rebuilt from the beat must be a legal 8-bit value
  assign centre_chk = {2'b00, median} + {residual[RES_W-1], residual};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(median) && $stable(residual))
    else $error("output beat changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a beat was taken");

  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while sequencer idle");

  a_centre_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !centre_chk[RES_W] && !centre_chk[RES_W-1])
    else $error("median plus residual out of sample range");

endmodule

bind sliding_window_median_residual swmr_chk u_swmr_chk (.*);
